>>> hdl/galois_rotation_finder_macros.svh
// Assertion macros shared by the checker of the rotation finder.
`ifndef GALOIS_ROTATION_FINDER_MACROS_SVH
`define GALOIS_ROTATION_FINDER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GRF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotation finder check failed");

// Consequent checked in the cycle after the antecedent.
`define GRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotation finder check failed");

`endif

>>> hdl/grf_pkg.sv
// Shared constants, codes and types of the rotation finder.
package grf_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int SYM_W = 8;
  localparam int RS_W = 10;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_PRIM   = 2'd1,
    ST_SCAN_LIMIT = 2'd2,
    ST_TOO_LONG   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    B_IDLE, B_PINIT, B_PRQ, B_PRK, B_PCMP, B_PFB, B_PCHK, B_PMOD,
    B_SINIT, B_TOP, B_ADDR, B_RED2, B_RED1, B_RD0, B_RD1, B_RD2,
    B_EVAL, B_CUT, B_FIN2, B_FIN1, B_REL, B_OUT
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic release_buf;
  } back_ctl_t;

endpackage

>>> hdl/grf_ram.sv
// Generic single-write, single-read memory with a registered read port.
module grf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/grf_queue.sv
// Two-entry job queue between the loading front and the scanning back.
module grf_queue #(
  parameter int WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && head_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && head_valid) ? 1 : 0);
    end
  end

endmodule

>>> hdl/grf_front.sv
// Front end: loads the string into the text store and queues a job at its last byte.
module grf_front #(
  parameter int MAX_LEN = grf_pkg::MAX_LEN_DEF,
  localparam int AW = $clog2(MAX_LEN),
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [grf_pkg::SYM_W-1:0] symbol,
  input  logic                     last,
  output logic                     text_we,
  output logic [AW-1:0]            text_waddr,
  output logic [grf_pkg::SYM_W-1:0] text_wdata,
  output logic                     job_push,
  output logic [LW:0]              job_data,
  input  logic                     job_full,
  input  logic                     release_buf
);

  logic [LW-1:0] len;
  logic          ovf;
  logic          hold;
  logic          accept;
  logic [LW-1:0] len_next;
  logic          ovf_next;

  assign item_stall = hold || job_full;
  assign accept     = item_valid && !item_stall;
  assign text_we    = accept && (len < LW'(MAX_LEN));
  assign text_waddr = len[AW-1:0];
  assign text_wdata = symbol;
  assign len_next   = text_we ? len + LW'(1) : len;
  assign ovf_next   = ovf || (accept && !text_we);
  assign job_push   = accept && last;
  assign job_data   = {ovf_next, len_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      ovf  <= 1'b0;
      hold <= 1'b0;
    end else begin
      if (job_push) begin
        len  <= '0;
        ovf  <= 1'b0;
        hold <= 1'b1;
      end else begin
        len <= len_next;
        ovf <= ovf_next;
        if (release_buf) begin
          hold <= 1'b0;
        end
      end
    end
  end

endmodule

>>> hdl/grf_back.sv
// Back end: period check with a border table, then the alternating-order scan.
module grf_back #(
  parameter int MAX_LEN = grf_pkg::MAX_LEN_DEF,
  localparam int AW = $clog2(MAX_LEN),
  localparam int LW = $clog2(MAX_LEN + 1),
  localparam int SW = LW + 2,
  localparam int RSW = grf_pkg::RS_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  logic [LW-1:0]             job_len,
  input  logic                      job_ovf,
  output grf_pkg::back_ctl_t        ctl,
  output logic [AW-1:0]             text_raddr,
  input  logic [grf_pkg::SYM_W-1:0] text_rdata,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [RSW-1:0]            rotation_start,
  output logic [1:0]                status
);

  grf_pkg::back_state_t state, state_next;
  grf_pkg::status_t     st;
  grf_pkg::status_t     res_status;

  logic [LW-1:0] n, q, rem, per;
  logic [AW-1:0] k, k_new;
  logic [SW-1:0] n2, lim, nx, i, j, pe, po, p, xc, xe, xo, start, ij;
  logic [SW-1:0] pe2, po2, pmin;
  logic [AW-1:0] ac, ae, ao;
  logic [grf_pkg::SYM_W-1:0] tq, c, de;
  logic          fallback, cut, even_j;
  logic          b_we;
  logic [AW-1:0] b_waddr, b_raddr, b_rdata, b_wdata;

  grf_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_border (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  assign nx       = SW'(n);
  assign ij       = i + j;
  assign fallback = (k != '0) && (tq != text_rdata);
  assign k_new    = k + AW'((tq == text_rdata) ? 1 : 0);
  assign even_j   = !j[0];

  always_comb begin
    cut  = 1'b0;
    pmin = '0;
    pe2  = pe;
    po2  = po;
    if (pe <= j) begin
      if (even_j ? (c < de) : (c > de)) begin
        cut  = 1'b1;
        pmin = pe;
      end else if (even_j ? (c > de) : (c < de)) begin
        pe2 = even_j ? j + SW'(2) : j + SW'(1);
      end
    end
    if (po <= j) begin
      if (even_j ? (c < text_rdata) : (c > text_rdata)) begin
        po2 = even_j ? j + SW'(1) : j + SW'(2);
      end else if (even_j ? (c > text_rdata) : (c < text_rdata)) begin
        if (!cut || (po < pmin)) begin
          pmin = po;
        end
        cut = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grf_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    ctl.pop         = 1'b0;
    ctl.release_buf = 1'b0;
    text_raddr      = '0;
    b_we            = 1'b0;
    b_waddr         = q[AW-1:0];
    b_wdata         = k_new;
    b_raddr         = k - AW'(1);
    case (state)
      grf_pkg::B_IDLE: begin
        if (job_valid) begin
          ctl.pop    = 1'b1;
          state_next = job_ovf ? grf_pkg::B_REL : grf_pkg::B_PINIT;
        end
      end
      grf_pkg::B_PINIT: begin
        b_we       = 1'b1;
        b_waddr    = '0;
        b_wdata    = '0;
        state_next = (n == LW'(1)) ? grf_pkg::B_PCHK : grf_pkg::B_PRQ;
      end
      grf_pkg::B_PRQ: begin
        text_raddr = q[AW-1:0];
        state_next = grf_pkg::B_PRK;
      end
      grf_pkg::B_PRK: begin
        text_raddr = k;
        state_next = grf_pkg::B_PCMP;
      end
      grf_pkg::B_PCMP: begin
        if (fallback) begin
          state_next = grf_pkg::B_PFB;
        end else begin
          b_we       = 1'b1;
          state_next = (q + LW'(1) == n) ? grf_pkg::B_PCHK : grf_pkg::B_PRQ;
        end
      end
      grf_pkg::B_PFB: begin
        text_raddr = q[AW-1:0];
        state_next = grf_pkg::B_PRK;
      end
      grf_pkg::B_PCHK:  state_next = (k == '0) ? grf_pkg::B_SINIT : grf_pkg::B_PMOD;
      grf_pkg::B_PMOD: begin
        if (rem < per) begin
          state_next = (rem == '0) ? grf_pkg::B_REL : grf_pkg::B_SINIT;
        end
      end
      grf_pkg::B_SINIT: state_next = grf_pkg::B_TOP;
      grf_pkg::B_TOP:   state_next = (i >= lim) ? grf_pkg::B_REL : grf_pkg::B_ADDR;
      grf_pkg::B_ADDR:  state_next = (ij >= lim) ? grf_pkg::B_REL : grf_pkg::B_RED2;
      grf_pkg::B_RED2:  state_next = grf_pkg::B_RED1;
      grf_pkg::B_RED1:  state_next = grf_pkg::B_RD0;
      grf_pkg::B_RD0: begin
        text_raddr = ac;
        state_next = grf_pkg::B_RD1;
      end
      grf_pkg::B_RD1: begin
        text_raddr = ae;
        state_next = grf_pkg::B_RD2;
      end
      grf_pkg::B_RD2: begin
        text_raddr = ao;
        state_next = grf_pkg::B_EVAL;
      end
      grf_pkg::B_EVAL: begin
        if (cut) begin
          state_next = grf_pkg::B_CUT;
        end else if ((pe2 >= nx) && (po2 >= nx)) begin
          state_next = grf_pkg::B_FIN2;
        end else begin
          state_next = grf_pkg::B_ADDR;
        end
      end
      grf_pkg::B_CUT:  state_next = (j >= p) ? grf_pkg::B_CUT : grf_pkg::B_TOP;
      grf_pkg::B_FIN2: state_next = grf_pkg::B_FIN1;
      grf_pkg::B_FIN1: state_next = grf_pkg::B_REL;
      grf_pkg::B_REL: begin
        ctl.release_buf = 1'b1;
        state_next      = grf_pkg::B_OUT;
      end
      grf_pkg::B_OUT: begin
        if (!result_valid || !result_stall) begin
          state_next = grf_pkg::B_IDLE;
        end
      end
      default: state_next = grf_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      grf_pkg::B_IDLE: begin
        n     <= job_len;
        st    <= job_ovf ? grf_pkg::ST_TOO_LONG : grf_pkg::ST_OK;
        start <= '0;
      end
      grf_pkg::B_PINIT: begin
        k <= '0;
        q <= LW'(1);
      end
      grf_pkg::B_PRK: tq <= text_rdata;
      grf_pkg::B_PCMP: begin
        if (!fallback) begin
          k <= k_new;
          q <= q + LW'(1);
        end
      end
      grf_pkg::B_PFB: k <= b_rdata;
      grf_pkg::B_PCHK: begin
        per <= n - LW'(k);
        rem <= n;
        n2  <= nx + nx;
      end
      grf_pkg::B_PMOD: begin
        if (rem >= per) begin
          rem <= rem - per;
        end else if (rem == '0) begin
          st <= grf_pkg::ST_NOT_PRIM;
        end
      end
      grf_pkg::B_SINIT: begin
        lim <= n2 + nx;
        i   <= '0;
      end
      grf_pkg::B_TOP: begin
        if (i >= lim) begin
          st <= grf_pkg::ST_SCAN_LIMIT;
        end
        po <= SW'(1);
        pe <= SW'(2);
        j  <= SW'(1);
      end
      grf_pkg::B_ADDR: begin
        if (ij >= lim) begin
          st <= grf_pkg::ST_SCAN_LIMIT;
        end
        xc <= ij;
        xe <= ij - pe;
        xo <= ij - po;
      end
      grf_pkg::B_RED2: begin
        xc <= (xc >= n2) ? xc - n2 : xc;
        xe <= (xe >= n2) ? xe - n2 : xe;
        xo <= (xo >= n2) ? xo - n2 : xo;
      end
      grf_pkg::B_RED1: begin
        ac <= AW'((xc >= nx) ? xc - nx : xc);
        ae <= AW'((xe >= nx) ? xe - nx : xe);
        ao <= AW'((xo >= nx) ? xo - nx : xo);
      end
      grf_pkg::B_RD1: c <= text_rdata;
      grf_pkg::B_RD2: de <= text_rdata;
      grf_pkg::B_EVAL: begin
        if (cut) begin
          p <= pmin;
        end else begin
          pe <= pe2;
          po <= po2;
          j  <= j + SW'(1);
          xc <= i;
        end
      end
      grf_pkg::B_CUT: begin
        if (j >= p) begin
          i <= i + p;
          j <= j - p;
          p <= pe;
        end
      end
      grf_pkg::B_FIN2: xc <= (xc >= n2) ? xc - n2 : xc;
      grf_pkg::B_FIN1: start <= (xc >= nx) ? xc - nx : xc;
      grf_pkg::B_OUT: begin
        if (!result_valid || !result_stall) begin
          rotation_start <= (st == grf_pkg::ST_OK) ? RSW'(start) : '0;
          res_status     <= st;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == grf_pkg::B_OUT) && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  assign status = res_status;

endmodule

>>> hdl/galois_rotation_finder.sv
// Top level of the rotation finder: front end, job queue, text store and back end.
// Usage: the string is sent one byte per transaction on the item channel (symbol,
// last), with last set on its final byte. One result transaction follows each
// string on the result channel: rotation_start and status (0 ok, 1 not primitive,
// 2 scan limit exceeded, 3 string too long; rotation_start is 0 unless ok).
// Bytes are loaded at one per cycle while item_stall is low. Once the last
// byte is in, item_stall stays high while the back end works on the stored
// string, since the single text store holds it. The border table pass reads
// two text bytes for each byte and steps back along the border chain on a
// mismatch, the primitivity check subtracts the period repeatedly, and each
// step of the scan reads three bytes and may shift the start offset, all through
// the single read port of the text store. Bytes past MAX_LEN are dropped and flagged.
// After the back end has finished reading, the next string is loaded while the
// result waits in the output register; a stalled result holds its value.
// Reset is synchronous and leaves the block empty and ready for a new string.
module galois_rotation_finder #(
  parameter int MAX_LEN = grf_pkg::MAX_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [grf_pkg::SYM_W-1:0] symbol,
  input  logic                      last,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [grf_pkg::RS_W-1:0]  rotation_start,
  output logic [1:0]                status
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic                      text_we;
  logic [AW-1:0]             text_waddr, text_raddr;
  logic [grf_pkg::SYM_W-1:0] text_wdata, text_rdata;
  logic                      job_push, job_full, job_valid;
  logic [LW:0]               job_in, job_head;
  grf_pkg::back_ctl_t        ctl;

  grf_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .symbol(symbol), .last(last),
    .text_we(text_we), .text_waddr(text_waddr), .text_wdata(text_wdata),
    .job_push(job_push), .job_data(job_in), .job_full(job_full),
    .release_buf(ctl.release_buf)
  );

  grf_queue #(.WIDTH(LW + 1)) u_queue (
    .clk(clk), .rst(rst),
    .push(job_push), .push_data(job_in), .full(job_full),
    .pop(ctl.pop), .head_valid(job_valid), .head(job_head)
  );

  grf_ram #(.WIDTH(grf_pkg::SYM_W), .DEPTH(MAX_LEN)) u_text (
    .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(text_wdata),
    .raddr(text_raddr), .rdata(text_rdata)
  );

  grf_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_len(job_head[LW-1:0]), .job_ovf(job_head[LW]),
    .ctl(ctl),
    .text_raddr(text_raddr), .text_rdata(text_rdata),
    .result_valid(result_valid), .result_stall(result_stall),
    .rotation_start(rotation_start), .status(status)
  );

endmodule

>>> hdl/grf_checker.sv
// Port-level checks of the rotation finder and their binding to the top level.
`include "galois_rotation_finder_macros.svh"

module grf_checker #(
  parameter int MAX_LEN = grf_pkg::MAX_LEN_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     result_valid,
  input logic                     result_stall,
  input logic [grf_pkg::RS_W-1:0] rotation_start,
  input logic [1:0]               status
);

  `GRF_ASSERT_SAME(a_fail_zero, result_valid && (status != grf_pkg::ST_OK), rotation_start == '0)
  `GRF_ASSERT_SAME(a_start_range, result_valid, rotation_start < MAX_LEN)
  `GRF_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(rotation_start) && $stable(status))

endmodule

bind galois_rotation_finder grf_checker #(.MAX_LEN(MAX_LEN)) u_grf_checker (.*);
